FILE: rtl/pol_pkg.sv
`default_nettype none

package pol_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int POS_W        = 7;
    localparam int GROUP_SIZE   = 8;
    localparam int GROUP_IDX_W  = $clog2(GROUP_SIZE);

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_READ   = 3'd2,
        ACT_FIND   = 3'd3,
        ACT_CLEAR  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_REDUCE
    } state_t;

    typedef struct packed {
        logic [2:0]              action;
        logic [POS_W-1:0]        position;
        logic signed [KEY_W-1:0] key_value;
    } req_item_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        logic [POS_W-1:0]        position_out;
        status_t                 status;
        logic [POS_W-1:0]        entry_count;
    } rsp_item_t;

    typedef struct packed {
        logic             do_insert;
        logic             do_remove;
        logic [KEY_W-1:0] key;
    } cell_ctrl_t;

    typedef struct packed {
        logic                   found;
        logic [GROUP_IDX_W-1:0] idx;
        logic [KEY_W-1:0]       key;
    } group_res_t;

endpackage

`default_nettype wire

FILE: rtl/pol_cell.sv
`default_nettype none

module pol_cell
    import pol_pkg::*;
#(
    parameter int CW    = POS_W,
    parameter int INDEX = 0
)
(
    input  wire logic             clk,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [CW-1:0]    pos,
    input  wire logic [CW-1:0]    count,
    input  wire logic [KEY_W-1:0] left_data,
    input  wire logic [KEY_W-1:0] right_data,
    output logic      [KEY_W-1:0] data,
    output logic                  hit_pos,
    output logic                  hit_key
);

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic [KEY_W-1:0] data_reg;
    logic [KEY_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        priority if (ctrl.do_insert)
        begin
            priority if (IDX > pos)
                data_next = left_data;
            else if (IDX == pos)
                data_next = ctrl.key;
            else
                data_next = data_reg;
        end
        else if (ctrl.do_remove && (IDX >= pos))
        begin
            data_next = right_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign hit_pos = (IDX == pos);
    assign hit_key = (IDX < count) && (data_reg == ctrl.key);

endmodule

`default_nettype wire

FILE: rtl/pol_group.sv
`default_nettype none

module pol_group
    import pol_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [KEY_W-1:0] data [GROUP_SIZE],
    input  wire logic             hit_pos [GROUP_SIZE],
    input  wire logic             hit_key [GROUP_SIZE],
    output group_res_t            res
);

    group_res_t res_reg;
    group_res_t res_next;

    // first key match wins; position hit is one-hot so an OR picks the key
    always_comb
    begin
        res_next = '0;
        for (int i = GROUP_SIZE - 1; i >= 0; i--)
        begin
            if (hit_key[i])
            begin
                res_next.found = 1'b1;
                res_next.idx   = GROUP_IDX_W'(i);
            end
        end
        for (int i = 0; i < GROUP_SIZE; i++)
        begin
            res_next.key = res_next.key | (hit_pos[i] ? data[i] : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

FILE: rtl/positional_ordered_list.sv
// A transaction accepted in S_IDLE is captured in the group result registers and, in S_REDUCE,
// is loaded into the output register once that register is free.
// No new request is taken until the response is loaded; S_REDUCE is the registered reduction
// over the cell groups that picks the read key and the first matching position.
// Shifts for insert and remove happen in the row of cells in the accept cycle.
// Reset clears the entry count, the control state and the output valid; entry data is not reset.
`default_nettype none

module positional_ordered_list
    import pol_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire req_item_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output rsp_item_t      rsp
);

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CW      = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int NGROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int NPAD    = NGROUPS * GROUP_SIZE;

    state_t state_reg;
    state_t state_next;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic [2:0]    act_reg;
    status_t       st_reg;
    logic          key_sel_reg;
    logic [CW-1:0] cnt_before_reg;

    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    rsp_item_t rsp_reg;
    rsp_item_t rsp_next;

    logic          accept;
    logic          load_out;
    logic [CW-1:0] pos;
    logic          ins_ok;
    logic          rem_ok;
    logic          rd_ok;
    status_t       st_pre;
    cell_ctrl_t    ctrl;

    logic [KEY_W-1:0] cell_data [NPAD];
    logic             cell_hit_pos [NPAD];
    logic             cell_hit_key [NPAD];
    group_res_t       grp [NGROUPS];

    assign accept = req_valid && req_ready;
    assign pos    = CW'(req.position);

    always_comb
    begin
        ins_ok     = 1'b0;
        rem_ok     = 1'b0;
        rd_ok      = 1'b0;
        st_pre     = ST_OK;
        count_next = count_reg;
        unique case (req.action)
            ACT_INSERT:
            begin
                priority if (pos > count_reg)
                    st_pre = ST_BAD_INDEX;
                else if (count_reg >= CW'(CAPACITY))
                    st_pre = ST_FULL;
                else
                begin
                    ins_ok     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            ACT_REMOVE:
            begin
                if (pos >= count_reg)
                    st_pre = ST_BAD_INDEX;
                else
                begin
                    rem_ok     = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            ACT_READ:
            begin
                if (pos >= count_reg)
                    st_pre = ST_BAD_INDEX;
                else
                    rd_ok = 1'b1;
            end
            ACT_FIND:
            begin
                st_pre = ST_NOT_FOUND;
            end
            ACT_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                st_pre = ST_BAD_INDEX;
            end
        endcase
    end

    assign ctrl.do_insert = accept && ins_ok;
    assign ctrl.do_remove = accept && rem_ok;
    assign ctrl.key       = req.key_value;

    generate
        for (genvar i = 0; i < NPAD; i++)
        begin : g_cell
            if (i < CAPACITY)
            begin : g_real
                logic [KEY_W-1:0] left_d;
                logic [KEY_W-1:0] right_d;
                if (i == 0)
                begin : g_first
                    assign left_d = req.key_value;
                end
                else
                begin : g_mid_l
                    assign left_d = cell_data[i-1];
                end
                if (i == CAPACITY - 1)
                begin : g_last
                    assign right_d = cell_data[i];
                end
                else
                begin : g_mid_r
                    assign right_d = cell_data[i+1];
                end
                pol_cell #(
                    .CW    (CW),
                    .INDEX (i)
                ) u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .pos        (pos),
                    .count      (count_reg),
                    .left_data  (left_d),
                    .right_data (right_d),
                    .data       (cell_data[i]),
                    .hit_pos    (cell_hit_pos[i]),
                    .hit_key    (cell_hit_key[i])
                );
            end
            else
            begin : g_pad
                assign cell_data[i]    = '0;
                assign cell_hit_pos[i] = 1'b0;
                assign cell_hit_key[i] = 1'b0;
            end
        end

        for (genvar g = 0; g < NGROUPS; g++)
        begin : g_grp
            pol_group u_group (
                .clk     (clk),
                .en      (accept),
                .data    (cell_data[g*GROUP_SIZE +: GROUP_SIZE]),
                .hit_pos (cell_hit_pos[g*GROUP_SIZE +: GROUP_SIZE]),
                .hit_key (cell_hit_key[g*GROUP_SIZE +: GROUP_SIZE]),
                .res     (grp[g])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg        <= req.action;
            st_reg         <= st_pre;
            key_sel_reg    <= rem_ok || rd_ok;
            cnt_before_reg <= count_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
            end
            S_REDUCE:
            begin
                load_out = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // final reduction across groups
    always_comb
    begin
        logic          found;
        logic [CW-1:0] fpos;
        logic [KEY_W-1:0] key_any;
        found   = 1'b0;
        fpos    = '0;
        key_any = '0;
        for (int g = NGROUPS - 1; g >= 0; g--)
        begin
            if (grp[g].found)
            begin
                found = 1'b1;
                fpos  = CW'(g * GROUP_SIZE) + CW'(grp[g].idx);
            end
        end
        for (int g = 0; g < NGROUPS; g++)
        begin
            key_any = key_any | grp[g].key;
        end

        rsp_next              = '0;
        rsp_next.entry_count  = count_reg[POS_W-1:0];
        rsp_next.status       = st_reg;
        rsp_next.key_out      = key_sel_reg ? key_any : '0;
        if (act_reg == ACT_FIND)
        begin
            rsp_next.status       = found ? ST_OK : ST_NOT_FOUND;
            rsp_next.position_out = found ? fpos[POS_W-1:0] : cnt_before_reg[POS_W-1:0];
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        priority if (load_out)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
